// ===== design/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// efd_pkg
// Shared constants and types for the escape frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    localparam int BYTE_W      = 8;
    localparam int BUFFER_LEN  = 64;
    localparam int LEN_W       = 6;
    localparam int ADDR_W      = 6;
    localparam int CFG_IDX_W   = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE    = 8'd1;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd92;
    localparam logic [BYTE_W-1:0] END_RESET    = 8'd48;

    // one finished frame waiting to be played out
    typedef struct packed {
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
    } frame_desc_t;

    // store read request from the back end
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

endpackage

`default_nettype wire

// ===== design/escape_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_frame_decoder
// Byte-stuffed frame receiver with a decoupled frame player.
// ----------------------------------------------------------------------------
// Bytes arrive on the s_ channel one per transfer. An escape byte arms a
// flag; escape+escape stores a literal escape, escape+end closes a frame,
// escape+other sets the command and empties the store. On a close the
// frame goes to a two-entry descriptor queue and is played out on the m_
// channel, one transfer per payload byte (one transfer with has_data low
// for an empty frame), last marking the final byte.
// Input: one byte per cycle while no frame is being played out. While one
// is, bytes keep flowing as long as they append past the frame's end; any
// byte waits while the fill is on an entry still being played out (after
// a new command or an overflow), as does any byte when the queue is full.
// Output: a closed frame goes through the queue and the player's read
// state (an empty one skips it); each byte is read from the frame store
// into a register, and the next read waits until that byte is taken.
// Reset clears the escape flag, fill and command and restores the escape
// (92) and end (48) codes. A stalled m_ready holds the current result; the
// input side keeps going until the queue or the store lock stops it.
// Configuration writes on cfg_ are always ready and take effect next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_frame_decoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [efd_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [efd_pkg::BYTE_W-1:0]          m_frame_command,
    output logic [efd_pkg::BYTE_W-1:0]          m_msg_byte,
    output logic [efd_pkg::LEN_W-1:0]           m_msg_length,
    output logic                                m_has_data,
    output logic                                m_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]     cfg_data
);
    import efd_pkg::*;

    logic              enq_valid;
    frame_desc_t       enq_desc;
    logic              q_full;
    logic              q_valid;
    frame_desc_t       q_desc;
    logic              q_pop;
    logic              back_busy;
    logic              pending;
    rd_req_t           rd_req;
    logic [BYTE_W-1:0] rd_data;

    assign pending = q_valid || back_busy;

    efd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .enq_valid (enq_valid),
        .enq_desc  (enq_desc),
        .q_full    (q_full),
        .pending   (pending),
        .rd_req    (rd_req),
        .rd_data   (rd_data)
    );

    efd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (enq_valid),
        .push_desc  (enq_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_desc)
    );

    efd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_desc          (q_desc),
        .q_pop           (q_pop),
        .busy            (back_busy),
        .rd_req          (rd_req),
        .rd_data         (rd_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_command (m_frame_command),
        .m_msg_byte      (m_msg_byte),
        .m_msg_length    (m_msg_length),
        .m_has_data      (m_has_data),
        .m_last          (m_last)
    );

endmodule

`default_nettype wire

// ===== design/efd_queue.sv =====
// ----------------------------------------------------------------------------
// efd_queue
// Short descriptor queue between the byte classifier and the frame player.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire efd_pkg::frame_desc_t push_desc,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output efd_pkg::frame_desc_t      head_desc
);
    import efd_pkg::*;

    frame_desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire

// ===== design/efd_front.sv =====
// ----------------------------------------------------------------------------
// efd_front
// Byte classifier: escape tracking, command capture, frame store and the
// configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [efd_pkg::BYTE_W-1:0]     s_rx_byte,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]     cfg_data,
    output logic                                enq_valid,
    output efd_pkg::frame_desc_t                enq_desc,
    input  wire logic                           q_full,
    input  wire logic                           pending,
    input  wire efd_pkg::rd_req_t               rd_req,
    output logic [efd_pkg::BYTE_W-1:0]          rd_data
);
    import efd_pkg::*;

    localparam logic [LEN_W:0] BUF_LIMIT = (LEN_W+1)'(BUFFER_LEN);

    logic [BYTE_W-1:0] esc_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  lock_reg, lock_next;
    logic [BYTE_W-1:0] store_mem [BUFFER_LEN];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              accept;
    logic              is_esc, is_end;
    logic              wr_en;
    logic [LEN_W:0]    fill_inc;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign is_esc    = (s_rx_byte == esc_code_reg);
    assign is_end    = (s_rx_byte == end_code_reg);
    assign fill_inc  = {1'b0, fill_reg} + (LEN_W+1)'(1);

    // entries below lock_reg still belong to a frame being played out
    assign s_ready = !q_full && (!pending || (fill_reg >= lock_reg));

    assign enq_desc.command = cmd_reg;
    assign enq_desc.length  = fill_reg;
    assign rd_data          = rd_data_reg;

    always_comb begin
        pend_next = pend_reg;
        fill_next = fill_reg;
        cmd_next  = cmd_reg;
        wr_en     = 1'b0;
        enq_valid = 1'b0;
        if (accept) begin
            if (is_esc && !pend_reg) begin
                pend_next = 1'b1;
            end else if (!is_esc && pend_reg) begin
                pend_next = 1'b0;
                if (is_end) begin
                    enq_valid = 1'b1;
                end else begin
                    cmd_next  = s_rx_byte;
                    fill_next = '0;
                end
            end else begin
                // plain byte or literal escape
                pend_next = 1'b0;
                wr_en     = 1'b1;
                if (fill_inc >= BUF_LIMIT) begin
                    fill_next = '0;
                end else begin
                    fill_next = fill_inc[LEN_W-1:0];
                end
            end
        end
    end

    always_comb begin
        lock_next = lock_reg;
        if (enq_valid) begin
            lock_next = (pending && (lock_reg > fill_reg)) ? lock_reg : fill_reg;
        end else if (!pending) begin
            lock_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_code_reg <= ESCAPE_RESET;
            end_code_reg <= END_RESET;
            pend_reg     <= 1'b0;
            fill_reg     <= '0;
            cmd_reg      <= '0;
            lock_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ESCAPE_CODE: esc_code_reg <= cfg_data;
                    CFG_END_CODE:    end_code_reg <= cfg_data;
                    default:         ;
                endcase
            end
            pend_reg <= pend_next;
            fill_reg <= fill_next;
            cmd_reg  <= cmd_next;
            lock_reg <= lock_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[fill_reg] <= s_rx_byte;
        end
        if (rd_req.en) begin
            rd_data_reg <= store_mem[rd_req.addr];
        end
    end

    a_write_clear_of_reader: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && pending) |-> (fill_reg >= lock_reg))
        else $error("store write into an entry still being played out");

    a_read_below_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_req.en |-> (rd_req.addr < lock_reg))
        else $error("store read outside the locked frame");

endmodule

`default_nettype wire

// ===== design/efd_back.sv =====
// ----------------------------------------------------------------------------
// efd_back
// Frame player: takes one descriptor at a time and sends its bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire efd_pkg::frame_desc_t           q_desc,
    output logic                                q_pop,
    output logic                                busy,
    output efd_pkg::rd_req_t                    rd_req,
    input  wire logic [efd_pkg::BYTE_W-1:0]     rd_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [efd_pkg::BYTE_W-1:0]          m_frame_command,
    output logic [efd_pkg::BYTE_W-1:0]          m_msg_byte,
    output logic [efd_pkg::LEN_W-1:0]           m_msg_length,
    output logic                                m_has_data,
    output logic                                m_last
);
    import efd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    assign busy            = (state_reg != ST_IDLE);
    assign q_pop           = q_valid && (state_reg == ST_IDLE);
    assign rd_req.en       = (state_reg == ST_READ);
    assign rd_req.addr     = idx_reg;
    assign m_valid         = (state_reg == ST_SEND);
    assign m_frame_command = cmd_reg;
    assign m_msg_length    = len_reg;
    assign m_has_data      = (len_reg != '0);
    assign m_msg_byte      = m_has_data ? rd_data : '0;
    assign m_last          = !m_has_data || (idx_reg == len_reg - 1'b1);

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next   = q_desc.command;
                    len_next   = q_desc.length;
                    idx_next   = '0;
                    // empty frame skips the store read
                    state_next = (q_desc.length == '0) ? ST_SEND : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_ready) begin
                    if (m_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        len_reg <= len_next;
        idx_reg <= idx_next;
    end

    a_read_then_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |=> (state_reg == ST_SEND))
        else $error("store read not followed by a send");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (state_reg == ST_IDLE))
        else $error("player did not return to idle after the last byte");

endmodule

`default_nettype wire

// ===== bench/escape_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// escape_frame_decoder_tb
// Self-checking bench for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
// Streams received bytes into the decoder: a handful of hand-picked frames,
// a full-store frame and overflow, then random well-formed frames mixed with
// noise and abandoned frames, under several escape/end code settings.
// A scoreboard decodes each accepted byte on its own copy of the receiver
// state and queues the message beats that a close should produce. Every
// beat on the m_ channel is checked against the oldest queued one.
// ----------------------------------------------------------------------------
module escape_frame_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import efd_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_END_CODE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX   = {CFG_IDX_W{1'b1}};

    class frame_scoreboard;
        typedef struct {
            logic [BYTE_W-1:0] command;
            logic [BYTE_W-1:0] data;
            logic [LEN_W-1:0]  length;
            logic              has_data;
            logic              last;
        } msg_beat_t;

        logic [BYTE_W-1:0] esc_code;
        logic [BYTE_W-1:0] end_code;
        bit                escape_armed;
        logic [LEN_W-1:0]  fill;
        logic [BYTE_W-1:0] store [BUFFER_LEN];
        logic [BYTE_W-1:0] command;
        msg_beat_t         msg_queue [$];
        int                errors;

        function new();
            esc_code     = ESCAPE_RESET;
            end_code     = END_RESET;
            escape_armed = 1'b0;
            fill         = '0;
            command      = '0;
            errors       = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
            if (idx == CFG_ESCAPE_CODE) begin
                esc_code = value;
            end else if (idx == CFG_END_CODE) begin
                end_code = value;
            end
        endfunction

        function void queue_frame();
            msg_beat_t beat;
            beat.command = command;
            if (fill == 0) begin
                beat.data     = '0;
                beat.length   = '0;
                beat.has_data = 1'b0;
                beat.last     = 1'b1;
                msg_queue.push_back(beat);
            end else begin
                for (int k = 0; k < fill; k++) begin
                    beat.data     = store[k];
                    beat.length   = fill;
                    beat.has_data = 1'b1;
                    beat.last     = (k + 1 == fill);
                    msg_queue.push_back(beat);
                end
            end
        endfunction

        function void take_rx_byte(logic [BYTE_W-1:0] b);
            int next_fill;
            if (b == esc_code) begin
                if (!escape_armed) begin
                    escape_armed = 1'b1;
                    return;
                end
                // escape twice: falls through as a literal
                escape_armed = 1'b0;
            end else if (escape_armed) begin
                escape_armed = 1'b0;
                if (b == end_code) begin
                    queue_frame();
                    return;
                end
                command = b;
                fill    = '0;
                return;
            end
            store[fill] = b;
            next_fill = int'(fill) + 1;
            // full store drops the partial frame without a result
            if (next_fill >= BUFFER_LEN) begin
                next_fill    = 0;
                escape_armed = 1'b0;
            end
            fill = next_fill[LEN_W-1:0];
        endfunction

        function void compare_field(string field, logic [BYTE_W-1:0] expected,
                                    logic [BYTE_W-1:0] actual);
            if (actual !== expected) begin
                $display("%0t: %s expected %0h got %0h", $time, field, expected, actual);
                errors++;
            end
        endfunction

        function void check_msg_beat(logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] data,
                                     logic [LEN_W-1:0] length, logic has_data,
                                     logic last);
            msg_beat_t exp_beat;
            if (msg_queue.size() == 0) begin
                $display("%0t: unexpected transfer, expected none got cmd %0h byte %0h",
                         $time, cmd, data);
                errors++;
                return;
            end
            exp_beat = msg_queue.pop_front();
            compare_field("frame_command", exp_beat.command, cmd);
            compare_field("msg_byte", exp_beat.data, data);
            compare_field("msg_length", BYTE_W'(exp_beat.length), BYTE_W'(length));
            compare_field("has_data", BYTE_W'(exp_beat.has_data), BYTE_W'(has_data));
            compare_field("last", BYTE_W'(exp_beat.last), BYTE_W'(last));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_frame_command;
    logic [BYTE_W-1:0]     m_msg_byte;
    logic [LEN_W-1:0]      m_msg_length;
    logic                  m_has_data;
    logic                  m_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0]     cfg_data;

    frame_scoreboard sb = new();
    int              items_sent = 0;
    int              cycles = 0;
    bit              in_burst = 1'b0;
    bit              out_burst = 1'b0;

    escape_frame_decoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_command (m_frame_command),
        .m_msg_byte      (m_msg_byte),
        .m_msg_length    (m_msg_length),
        .m_has_data      (m_has_data),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("escape_frame_decoder_tb failed");
            $finish;
        end
    end

    // transfer monitor: feeds the scoreboard on every handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.take_rx_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                sb.check_msg_beat(m_frame_command, m_msg_byte, m_msg_length,
                                  m_has_data, m_last);
            end
        end
    end

    // result side: random stall before each transfer, with bursts of none
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
            stall = out_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_literal(input logic [BYTE_W-1:0] b);
        send_byte(b);
        if (b == sb.esc_code) send_byte(b);
    endtask

    task automatic open_frame(input logic [BYTE_W-1:0] cmd);
        send_byte(sb.esc_code);
        send_byte(cmd);
    endtask

    task automatic close_frame();
        send_byte(sb.esc_code);
        send_byte(sb.end_code);
    endtask

    function automatic logic [BYTE_W-1:0] pick_command();
        logic [BYTE_W-1:0] c;
        do c = BYTE_W'($urandom_range(0, 255));
        while (c == sb.esc_code || c == sb.end_code);
        return c;
    endfunction

    // payload leans on the two code values to exercise stuffing
    function automatic logic [BYTE_W-1:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return sb.esc_code;
            1: return sb.end_code;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_payload(input int n);
        repeat (n) send_literal(pick_payload());
    endtask

    task automatic random_traffic(input int n_items);
        int target;
        int len;
        target = items_sent + n_items;
        while (items_sent < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    open_frame(pick_command());
                    send_payload(len);
                    close_frame();
                end
                6: begin
                    send_payload(len);
                    close_frame();
                end
                7: begin
                    close_frame();
                end
                8: begin
                    repeat ($urandom_range(1, 5)) begin
                        send_byte(($urandom_range(0, 3) == 0) ? sb.esc_code
                                                              : 8'($urandom_range(0, 255)));
                    end
                end
                default: begin
                    // frame abandoned before its close
                    open_frame(pick_command());
                    send_payload(len);
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.msg_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] term);
        wait_idle();
        cfg_write(CFG_ESCAPE_CODE, esc);
        cfg_write(CFG_END_CODE, term);
        // writes to unused indexes must be ignored
        cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                  BYTE_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [BYTE_W-1:0] rand_esc;
        logic [BYTE_W-1:0] rand_end;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset codes, no command seen yet
        close_frame();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sb.esc_code);
        send_byte(sb.esc_code);
        close_frame();
        open_frame(8'hFF);
        send_byte(8'h00);
        close_frame();
        // store survives a close, later bytes append
        close_frame();
        send_byte(8'h7F);
        close_frame();
        open_frame(8'h00);
        close_frame();

        // longest frame, then overflow back to empty
        open_frame(pick_command());
        send_payload(BUFFER_LEN - 1);
        close_frame();
        send_payload(1);
        close_frame();
        open_frame(pick_command());
        send_payload(BUFFER_LEN + 3);
        close_frame();

        random_traffic(70);
        wait_idle();
        random_traffic(40);

        set_codes(8'h00, 8'hFF);
        random_traffic(60);
        set_codes(8'hFF, 8'h00);
        random_traffic(60);

        // escape equal to end: no close can ever happen
        set_codes(8'h3C, 8'h3C);
        open_frame(pick_command());
        send_payload(4);
        close_frame();
        random_traffic(30);

        rand_esc = BYTE_W'($urandom_range(0, 255));
        do rand_end = BYTE_W'($urandom_range(0, 255));
        while (rand_end == rand_esc);
        set_codes(rand_esc, rand_end);
        random_traffic(60);

        set_codes(ESCAPE_RESET, END_RESET);
        random_traffic(80);

        wait_idle();
        if (sb.errors == 0) begin
            $display("escape_frame_decoder_tb passed");
        end else begin
            $display("escape_frame_decoder_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/efd_pkg.sv
design/efd_queue.sv
design/efd_front.sv
design/efd_back.sv
design/escape_frame_decoder.sv
bench/escape_frame_decoder_tb.sv
